// File: hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU key-value cache: beat payloads,
// controller states, and the command and status bundles.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KeyW   = 31;
  localparam int DataW  = 32;
  localparam int TouchW = 32;
  localparam int CfgW   = 5;

  localparam logic [CfgW-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [KeyW-1:0]         key;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] read_value;
    logic                    evicted;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVICT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load_req;
    logic lookup;
    logic commit_hit;
    logic commit_fill;
    logic commit_none;
    logic scan_start;
    logic scan_issue;
    logic commit_evict;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic is_put;
    logic cap_zero;
    logic fill_ok;
    logic scan_last;
  } status_t;

endpackage

// File: hdl/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Request sequencer: lookup, decision, victim scan, commit and result beat.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  lfu_pkg::status_t status_i,
  output lfu_pkg::cmd_t    cmd_o
);

  lfu_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      lfu_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = lfu_pkg::ST_LOOKUP;
        end
      end
      lfu_pkg::ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = lfu_pkg::ST_DECIDE;
      end
      lfu_pkg::ST_DECIDE: begin
        if (status_i.hit) begin
          cmd_o.commit_hit = 1'b1;
          state_d          = lfu_pkg::ST_RESP;
        end else if (!status_i.is_put || status_i.cap_zero) begin
          cmd_o.commit_none = 1'b1;
          state_d           = lfu_pkg::ST_RESP;
        end else if (status_i.fill_ok) begin
          cmd_o.commit_fill = 1'b1;
          state_d           = lfu_pkg::ST_RESP;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = lfu_pkg::ST_DRAIN;
        end
      end
      lfu_pkg::ST_DRAIN: begin
        // last slot is compared in this cycle
        state_d = lfu_pkg::ST_EVICT;
      end
      lfu_pkg::ST_EVICT: begin
        cmd_o.commit_evict = 1'b1;
        state_d            = lfu_pkg::ST_RESP;
      end
      lfu_pkg::ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = lfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == lfu_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/lfu_dpath.sv
// ----------------------------------------------------------------------------
// lfu_dpath
// Slot storage, parallel key compare, victim scan and result registers.
// ----------------------------------------------------------------------------
module lfu_dpath #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lfu_pkg::req_t              in_data_i,
  input  logic                       cfg_valid_i,
  input  logic [lfu_pkg::CfgW-1:0]   cfg_data_i,
  input  lfu_pkg::cmd_t              cmd_i,
  output lfu_pkg::status_t           status_o,
  output lfu_pkg::rsp_t              out_data_o
);

  localparam int IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FillW = $clog2(ENTRIES + 1);
  localparam int CmpW  = (FillW > lfu_pkg::CfgW) ? FillW : lfu_pkg::CfgW;
  localparam int MetaW = COUNT_BITS + lfu_pkg::TouchW;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  lfu_pkg::req_t                req_q;
  lfu_pkg::rsp_t                res_q, res_d, out_q;
  logic [lfu_pkg::CfgW-1:0]     cap_q;
  logic [ENTRIES-1:0]           valid_q;
  logic [lfu_pkg::KeyW-1:0]     key_q [ENTRIES];
  logic [FillW-1:0]             filled_q;
  logic [lfu_pkg::TouchW-1:0]   touch_q;
  logic                         hit_q, free_vld_q;
  logic [IdxW-1:0]              hit_idx_q, free_idx_q;
  logic [IdxW-1:0]              scan_cnt_q, cmp_idx_q, best_idx_q;
  logic                         cmp_vld_q, best_vld_q;
  logic [COUNT_BITS-1:0]        best_cnt_q;
  logic [lfu_pkg::TouchW-1:0]   best_age_q;

  logic                         hit_c, free_c;
  logic [IdxW-1:0]              hit_idx_c, free_idx_c, meta_raddr, wr_idx;
  logic [MetaW-1:0]             meta_rdata, meta_wdata;
  logic [lfu_pkg::DataW-1:0]    data_rdata;
  logic [COUNT_BITS-1:0]        rd_cnt, new_cnt;
  logic [lfu_pkg::TouchW-1:0]   rd_touch, age;
  logic                         take, ins_we, meta_we, data_we;
  logic [CmpW-1:0]              cap_ext, cap_eff;

  // parallel key compare and free-slot search, lowest index first
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    free_c     = 1'b0;
    free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (key_q[i] == req_q.key)) begin
        hit_c     = 1'b1;
        hit_idx_c = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_c     = 1'b1;
        free_idx_c = IdxW'(i);
      end
    end
  end

  assign rd_cnt   = meta_rdata[MetaW-1:lfu_pkg::TouchW];
  assign rd_touch = meta_rdata[lfu_pkg::TouchW-1:0];
  assign age      = touch_q - rd_touch;
  assign take     = cmp_vld_q && valid_q[cmp_idx_q] &&
                    (!best_vld_q || (rd_cnt < best_cnt_q) ||
                     ((rd_cnt == best_cnt_q) && (age > best_age_q)));

  assign meta_raddr = cmd_i.scan_issue ? scan_cnt_q : hit_idx_c;
  assign ins_we     = cmd_i.commit_fill || (cmd_i.commit_evict && best_vld_q);
  assign meta_we    = cmd_i.commit_hit || ins_we;
  assign data_we    = ins_we || (cmd_i.commit_hit && (req_q.op == lfu_pkg::OP_PUT));
  assign wr_idx     = cmd_i.commit_hit  ? hit_idx_q  :
                      cmd_i.commit_fill ? free_idx_q : best_idx_q;
  assign new_cnt    = cmd_i.commit_hit ?
                      ((rd_cnt == CountMax) ? rd_cnt : rd_cnt + 1'b1) :
                      COUNT_BITS'(1);
  assign meta_wdata = {new_cnt, touch_q};

  assign cap_ext = CmpW'(cap_q);
  assign cap_eff = (cap_ext > CmpW'(ENTRIES)) ? CmpW'(ENTRIES) : cap_ext;

  always_comb begin
    res_d = res_q;
    if (cmd_i.commit_hit) begin
      res_d.hit        = 1'b1;
      res_d.read_value = (req_q.op == lfu_pkg::OP_GET) ? data_rdata : '0;
      res_d.evicted    = 1'b0;
    end else if (cmd_i.commit_none || cmd_i.commit_fill) begin
      res_d = '0;
    end else if (cmd_i.commit_evict) begin
      res_d         = '0;
      res_d.evicted = best_vld_q;
    end
  end

  lfu_ram #(
    .WIDTH (MetaW),
    .DEPTH (ENTRIES)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (wr_idx),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  lfu_ram #(
    .WIDTH (lfu_pkg::DataW),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (wr_idx),
    .wdata_i (req_q.value),
    .raddr_i (hit_idx_c),
    .rdata_o (data_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= lfu_pkg::CAP_RESET;
      valid_q    <= '0;
      filled_q   <= '0;
      touch_q    <= '0;
      cmp_vld_q  <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (ins_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.commit_fill) begin
        filled_q <= filled_q + 1'b1;
      end
      if (meta_we) begin
        touch_q <= touch_q + 1'b1;
      end
      cmp_vld_q <= cmd_i.scan_issue;
      if (cmd_i.scan_start) begin
        best_vld_q <= 1'b0;
      end else if (take) begin
        best_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.lookup) begin
      hit_q      <= hit_c;
      hit_idx_q  <= hit_idx_c;
      free_vld_q <= free_c;
      free_idx_q <= free_idx_c;
    end
    if (ins_we) begin
      key_q[wr_idx] <= req_q.key;
    end
    if (cmd_i.scan_start) begin
      scan_cnt_q <= '0;
    end else if (cmd_i.scan_issue) begin
      scan_cnt_q <= scan_cnt_q + 1'b1;
    end
    cmp_idx_q <= scan_cnt_q;
    if (take) begin
      best_idx_q <= cmp_idx_q;
      best_cnt_q <= rd_cnt;
      best_age_q <= age;
    end
    res_q <= res_d;
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign status_o.hit       = hit_q;
  assign status_o.is_put    = (req_q.op == lfu_pkg::OP_PUT);
  assign status_o.cap_zero  = (cap_q == '0);
  assign status_o.fill_ok   = free_vld_q && (CmpW'(filled_q) < cap_eff);
  assign status_o.scan_last = (scan_cnt_q == IdxW'(ENTRIES - 1));
  assign out_data_o         = out_q;

endmodule

// File: hdl/lfu_cache_key_value_core.sv
// ----------------------------------------------------------------------------
// lfu_cache_key_value_core
// Fully associative key-value cache, least-frequently-used replacement with
// least-recently-used tie-break.
//
//   Channel | Signals                              | Beat
//   --------+--------------------------------------+-----------------------
//   in      | in_valid_i, in_ready_o, in_data_i    | op, key, value
//   out     | out_valid_o, out_ready_i, out_data_o | hit, read_value, evicted
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i | capacity_in_use
//
// One request at a time. Hit, miss and fill pass through the lookup, decide and
// result states; a put that evicts also runs the victim scan, reading one slot
// per cycle from the count/recency RAM, then the drain and evict states.
// Reset clears the valid bits, fill count and touch clock; no clearing pass.
// A stalled result waits in the output register while the next request is
// accepted; that request then holds in its last state until the register is
// free.
// ----------------------------------------------------------------------------
module lfu_cache_key_value_core #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lfu_pkg::req_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output lfu_pkg::rsp_t            out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [lfu_pkg::CfgW-1:0] cfg_data_i
);

  lfu_pkg::cmd_t    cmd;
  lfu_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lfu_dpath #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.evicted))
    else $error("result flags both hit and eviction");

  a_value_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.read_value != '0)) |-> out_data_o.hit)
    else $error("read value on a miss");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result beat without a request in progress");

  a_single_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.commit_hit, cmd.commit_fill, cmd.commit_none,
                cmd.commit_evict}) <= 1)
    else $error("more than one commit in a cycle");

endmodule
